[hdl/go_to_goal_velocity_controller_top_macros.svh]
// Assertion macros for the go-to-goal velocity controller.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gvc_pkg.sv]
// Shared widths, constants, types and the arctangent table of the controller.
package gvc_pkg;

    // Field widths
    localparam int POS_W      = 27;
    localparam int HEAD_W     = 19;
    localparam int GAIN_W     = 20;
    localparam int TOL_W      = 18;
    localparam int SPEED_W    = 20;
    localparam int RADIUS_W   = 20;
    localparam int RATE_W     = 22;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_R = 3'd5;

    // Register reset values
    localparam logic signed [POS_W-1:0] GOAL_X_RST     = 27'sd380109;
    localparam logic signed [POS_W-1:0] GOAL_Y_RST     = 27'sd609485;
    localparam logic [GAIN_W-1:0]       TURN_GAIN_RST  = 20'd65536;
    localparam logic [TOL_W-1:0]        HEAD_TOL_RST   = 18'd6554;
    localparam logic [SPEED_W-1:0]      SPEED_LIM_RST  = 20'd45875;
    localparam logic [RADIUS_W-1:0]     ARRIVAL_R_RST  = 20'd6554;

    // Datapath widths
    localparam int DXY_W      = POS_W + 1;   // goal minus position
    localparam int XY_W       = 32;          // CORDIC x/y with gain growth
    localparam int Z_W        = 20;          // accumulated angle
    localparam int ERR_W      = 21;          // heading error before wrap
    localparam int DIST_W     = XY_W - 1;
    localparam int KINV_W     = 30;
    localparam int DPROD_W    = DIST_W + KINV_W;
    localparam int RPROD_W    = 2 * ERR_W;
    localparam int RATEF_W    = RPROD_W - 16;
    localparam int ATAN_IDX_W = 5;

    localparam int CORDIC_STEPS_DEF = 16;

    // Angle constants, Q16.16
    localparam logic signed [Z_W-1:0]   Z_HALF_PI  = 20'sd102944;
    localparam logic signed [ERR_W-1:0] ERR_PI     = 21'sd205887;
    localparam logic signed [ERR_W-1:0] ERR_TWO_PI = 21'sd411775;

    // CORDIC gain correction 0.60725293 in Q2.30
    localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

    // Angular rate saturation bound
    localparam logic signed [RATEF_W-1:0] RATEF_MAX = 26'sd1647100;

    // CORDIC status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in Q16.16, rounded
    function automatic logic [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 20'd51472;
            5'd1:    val = 20'd30386;
            5'd2:    val = 20'd16055;
            5'd3:    val = 20'd8150;
            5'd4:    val = 20'd4091;
            5'd5:    val = 20'd2047;
            5'd6:    val = 20'd1024;
            5'd7:    val = 20'd512;
            5'd8:    val = 20'd256;
            5'd9:    val = 20'd128;
            5'd10:   val = 20'd64;
            5'd11:   val = 20'd32;
            5'd12:   val = 20'd16;
            5'd13:   val = 20'd8;
            5'd14:   val = 20'd4;
            5'd15:   val = 20'd2;
            5'd16:   val = 20'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hdl/gvc_if.sv]
// Valid/ready channel interfaces for pose samples and velocity commands.
interface gvc_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [gvc_pkg::POS_W-1:0]    pos_x;
    logic signed [gvc_pkg::POS_W-1:0]    pos_y;
    logic signed [gvc_pkg::HEAD_W-1:0]   heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface gvc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [gvc_pkg::SPEED_W-1:0]         linear_speed;
    logic signed [gvc_pkg::RATE_W-1:0]   angular_rate;
    logic                                arrived;

    modport source (output valid, output linear_speed, output angular_rate, output arrived,
                    input ready);
    modport sink   (input valid, input linear_speed, input angular_rate, input arrived,
                    output ready);
endinterface

[hdl/gvc_cordic.sv]
// Iterative vectoring-mode CORDIC: one micro-rotation per cycle.
module gvc_cordic #(
    parameter int STEPS = gvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [gvc_pkg::DXY_W-1:0]   dx,
    input  logic signed [gvc_pkg::DXY_W-1:0]   dy,
    output gvc_pkg::cordic_stat_t              stat,
    output logic signed [gvc_pkg::XY_W-1:0]    x_out,
    output logic signed [gvc_pkg::Z_W-1:0]     z_out
);
    import gvc_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic signed [XY_W-1:0] dx_ext, dy_ext;
    logic signed [XY_W-1:0] xs, ys;
    logic [Z_W-1:0]         atan_val;

    assign dx_ext   = XY_W'(dx);
    assign dy_ext   = XY_W'(dy);
    assign xs       = x_reg >>> cnt_reg;
    assign ys       = y_reg >>> cnt_reg;
    assign atan_val = atan_q16(ATAN_IDX_W'(cnt_reg));

    // Load with quadrant pre-rotation, then steer on the sign of y
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            if (dx_ext < 0)
            begin
                if (dy_ext >= 0)
                begin
                    x_next = dy_ext;
                    y_next = -dx_ext;
                    z_next = Z_HALF_PI;
                end
                else
                begin
                    x_next = -dy_ext;
                    y_next = dx_ext;
                    z_next = -Z_HALF_PI;
                end
            end
            else
            begin
                x_next = dx_ext;
                y_next = dy_ext;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + $signed(atan_val);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - $signed(atan_val);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign z_out     = z_reg;

endmodule

[hdl/go_to_goal_velocity_controller_top.sv]
// Top level of the go-to-goal velocity controller.
//
//  channel | dir | handshake    | payload
//  pose    | in  | valid/ready  | pos_x, pos_y, heading
//  cmd     | out | valid/ready  | linear_speed, angular_rate, arrived
//  cfg     | in  | cfg_we       | cfg_index, cfg_wdata
//
// A pose runs from transfer through the CORDIC iterations and the DIST,
// CHECK, RATE, SAT and FINISH steps to the output register; CHECK jumps to
// FINISH at the goal, and so does every later pose from idle. One pose is
// in work at a time; pose.ready is high only while the sequencer is idle. A
// result waiting on cmd.ready holds the sequencer in its final step. Reset is
// asynchronous and loads the register defaults; there is no clearing pass.
`include "go_to_goal_velocity_controller_top_macros.svh"

module go_to_goal_velocity_controller_top #(
    parameter int CORDIC_STEPS = gvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    gvc_pose_if.sink                           pose,
    gvc_cmd_if.source                          cmd,
    input  logic                               cfg_we,
    input  logic [gvc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gvc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gvc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ITER   = 3'd1;
    localparam logic [2:0] S_DIST   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_RATE   = 3'd4;
    localparam logic [2:0] S_SAT    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    // Configuration registers
    logic signed [POS_W-1:0] goal_x_reg;
    logic signed [POS_W-1:0] goal_y_reg;
    logic [GAIN_W-1:0]       turn_gain_reg;
    logic [TOL_W-1:0]        head_tol_reg;
    logic [SPEED_W-1:0]      speed_limit_reg;
    logic [RADIUS_W-1:0]     arrival_r_reg;

    // Control
    logic [2:0] state_reg, state_next;
    logic       reached_flag_reg, reached_flag_next;
    logic       out_valid_reg, out_valid_next;

    // Payload
    logic signed [HEAD_W-1:0]  hd_reg, hd_next;
    logic [DPROD_W-1:0]        dprod_reg, dprod_next;
    logic [DIST_W-1:0]         dist_reg, dist_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [RPROD_W-1:0] rprod_reg, rprod_next;
    logic [SPEED_W-1:0]        res_speed_reg, res_speed_next;
    logic signed [RATE_W-1:0]  res_rate_reg, res_rate_next;
    logic                      res_arr_reg, res_arr_next;
    logic [SPEED_W-1:0]        out_speed_reg, out_speed_next;
    logic signed [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic                      out_arr_reg, out_arr_next;

    // CORDIC hookup
    logic                   cordic_start;
    cordic_stat_t           cordic_stat;
    logic signed [DXY_W-1:0] dx, dy;
    logic signed [XY_W-1:0] cordic_x;
    logic signed [Z_W-1:0]  cordic_z;

    // Intermediate terms
    logic                      pose_xfer, cmd_xfer;
    logic [DIST_W-1:0]         ux;
    logic [DPROD_W-1:0]        dsum;
    logic [DIST_W-1:0]         dist_w;
    logic signed [ERR_W-1:0]   err_raw;
    logic signed [ERR_W-1:0]   err_wrap;
    logic signed [RPROD_W-1:0] rsum;
    logic signed [RATEF_W-1:0] rate_full;
    logic signed [RATEF_W-1:0] rate_sat;
    logic signed [ERR_W-1:0]   aerr;
    logic [SPEED_W-1:0]        speed_min;

    assign pose_xfer = pose.valid && pose.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    assign dx = DXY_W'(goal_x_reg) - DXY_W'(pose.pos_x);
    assign dy = DXY_W'(goal_y_reg) - DXY_W'(pose.pos_y);
    assign cordic_start = pose_xfer && !reached_flag_reg;

    gvc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx),
        .dy    (dy),
        .stat  (cordic_stat),
        .x_out (cordic_x),
        .z_out (cordic_z)
    );

    // Scale the CORDIC magnitude by the inverse gain, round half up
    assign ux     = cordic_x[XY_W-1] ? '0 : cordic_x[DIST_W-1:0];
    assign dsum   = dprod_reg + (DPROD_W'(1) << 29);
    assign dist_w = dsum[DPROD_W-1:30];

    // Heading error, wrapped into [-pi, pi]
    assign err_raw = ERR_W'(cordic_z) - ERR_W'(hd_reg);
    always_comb
    begin
        if (err_raw > ERR_PI)
        begin
            err_wrap = err_raw - ERR_TWO_PI;
        end
        else if (err_raw < -ERR_PI)
        begin
            err_wrap = err_raw + ERR_TWO_PI;
        end
        else
        begin
            err_wrap = err_raw;
        end
    end

    // Round and saturate the rate, gate the speed on heading error
    assign rsum      = rprod_reg + RPROD_W'(32768);
    assign rate_full = $signed(rsum[RPROD_W-1:16]);
    assign rate_sat  = (rate_full > RATEF_MAX)  ? RATEF_MAX :
                       (rate_full < -RATEF_MAX) ? -RATEF_MAX : rate_full;
    assign aerr      = (err_reg < 0) ? -err_reg : err_reg;
    assign speed_min = (dist_reg < DIST_W'(speed_limit_reg)) ? dist_reg[SPEED_W-1:0]
                                                             : speed_limit_reg;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        reached_flag_next = reached_flag_reg;
        hd_next           = hd_reg;
        dprod_next        = dprod_reg;
        dist_next         = dist_reg;
        err_next          = err_reg;
        rprod_next        = rprod_reg;
        res_speed_next    = res_speed_reg;
        res_rate_next     = res_rate_reg;
        res_arr_next      = res_arr_reg;
        out_valid_next    = out_valid_reg && !cmd_xfer;
        out_speed_next    = out_speed_reg;
        out_rate_next     = out_rate_reg;
        out_arr_next      = out_arr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pose_xfer)
                begin
                    hd_next = pose.heading;
                    if (reached_flag_reg)
                    begin
                        res_speed_next = '0;
                        res_rate_next  = '0;
                        res_arr_next   = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ITER;
                    end
                end
            end
            S_ITER:
            begin
                if (cordic_stat.done)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                dprod_next = DPROD_W'(ux) * DPROD_W'(KINV_Q30);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                dist_next = dist_w;
                err_next  = err_wrap;
                if (dist_w < DIST_W'(arrival_r_reg))
                begin
                    reached_flag_next = 1'b1;
                    res_speed_next    = '0;
                    res_rate_next     = '0;
                    res_arr_next      = 1'b1;
                    state_next        = S_FINISH;
                end
                else
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                rprod_next = RPROD_W'($signed({1'b0, turn_gain_reg})) * RPROD_W'(err_reg);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                res_rate_next  = RATE_W'(rate_sat);
                res_speed_next = ($unsigned(aerr) < ERR_W'(head_tol_reg)) ? speed_min : '0;
                res_arr_next   = 1'b0;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || cmd.ready)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = res_speed_reg;
                    out_rate_next  = res_rate_reg;
                    out_arr_next   = res_arr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            reached_flag_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            reached_flag_reg <= reached_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        hd_reg        <= hd_next;
        dprod_reg     <= dprod_next;
        dist_reg      <= dist_next;
        err_reg       <= err_next;
        rprod_reg     <= rprod_next;
        res_speed_reg <= res_speed_next;
        res_rate_reg  <= res_rate_next;
        res_arr_reg   <= res_arr_next;
        out_speed_reg <= out_speed_next;
        out_rate_reg  <= out_rate_next;
        out_arr_reg   <= out_arr_next;
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= GOAL_X_RST;
            goal_y_reg      <= GOAL_Y_RST;
            turn_gain_reg   <= TURN_GAIN_RST;
            head_tol_reg    <= HEAD_TOL_RST;
            speed_limit_reg <= SPEED_LIM_RST;
            arrival_r_reg   <= ARRIVAL_R_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GOAL_X:    goal_x_reg      <= $signed(cfg_wdata[POS_W-1:0]);
                REG_GOAL_Y:    goal_y_reg      <= $signed(cfg_wdata[POS_W-1:0]);
                REG_TURN_GAIN: turn_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_HEAD_TOL:  head_tol_reg    <= cfg_wdata[TOL_W-1:0];
                REG_SPEED_LIM: speed_limit_reg <= cfg_wdata[SPEED_W-1:0];
                REG_ARRIVAL_R: arrival_r_reg   <= cfg_wdata[RADIUS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Channel outputs
    assign pose.ready       = (state_reg == S_IDLE);
    assign cmd.valid        = out_valid_reg;
    assign cmd.linear_speed = out_speed_reg;
    assign cmd.angular_rate = out_rate_reg;
    assign cmd.arrived      = out_arr_reg;

    // Checks
    `GVC_ASSERT_NEXT(a_reached_sticky, reached_flag_reg, reached_flag_reg, "reached flag dropped")
    `GVC_ASSERT_NOW(a_arrived_zero, cmd.valid && cmd.arrived, cmd.linear_speed == '0 && cmd.angular_rate == '0, "nonzero command after arrival")
    `GVC_ASSERT_NOW(a_speed_cap, cmd.valid, cmd.linear_speed <= speed_limit_reg, "speed above limit")
    `GVC_ASSERT_NEXT(a_accept_path, pose_xfer, state_reg == S_ITER || state_reg == S_FINISH, "bad state after pose transfer")

endmodule
